// ===== hw/rtl/rnc_pkg.sv =====
// Package for the RGB normalized convolution filter unit.
// Holds shared constants, register indexes, payload structs and the back-end state type.
// No dependencies.
package rnc_pkg;

	localparam int CH_BITS      = 8;
	localparam int W_BITS       = 8;
	localparam int MAX_K        = 7;
	localparam int LINE_MAX_DEF = 1024;
	localparam int COL_W        = 12;
	localparam int ACC_W        = 24;
	localparam int SUM_W        = 14;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 11;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KSIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;

	// item kinds
	localparam logic FUNC_WEIGHT = 1'b0;
	localparam logic FUNC_PIXEL  = 1'b1;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic                     func;
		logic [2:0]               weight_row;
		logic [2:0]               weight_col;
		logic signed [W_BITS-1:0] weight_value;
		logic [CH_BITS-1:0]       in_red;
		logic [CH_BITS-1:0]       in_green;
		logic [CH_BITS-1:0]       in_blue;
		logic                     in_frame_end;
	} in_item_t;

	typedef struct packed {
		logic [CH_BITS-1:0] out_red;
		logic [CH_BITS-1:0] out_green;
		logic [CH_BITS-1:0] out_blue;
		logic               out_row_end;
		logic               out_frame_end;
		logic               zero_sum;
		logic               clipped;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                     is_pixel;
		logic [2:0]               w_row;
		logic [2:0]               w_col;
		logic signed [W_BITS-1:0] w_value;
		logic [CH_BITS-1:0]       red;
		logic [CH_BITS-1:0]       green;
		logic [CH_BITS-1:0]       blue;
		logic [COL_W-1:0]         col;
		logic [2:0]               slot;
		logic [2:0]               km1;
		logic                     fire;
		logic                     row_end;
		logic                     frame_end;
	} q_item_t;

	typedef struct packed {
		logic [CH_BITS-1:0] val;
		logic               clip;
	} chan_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAPS,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} back_state_t;

endpackage

// ===== hw/rtl/rnc_front.sv =====
// Front end: configuration registers, raster position tracking and item queue.
// Depends on rnc_pkg.
module rnc_front #(
	parameter int LINE_MAX = rnc_pkg::LINE_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rnc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rnc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  rnc_pkg::in_item_t                 item,
	output logic                              q_valid,
	input  logic                              q_pop,
	output rnc_pkg::q_item_t                  q_item
);
	import rnc_pkg::*;

	localparam int CW = $clog2(LINE_MAX);

	logic [1:0]            ksel_q;
	logic [CFG_DATA_W-1:0] pw_q;
	logic [CW-1:0]         col_q;
	logic [2:0]            row_q;
	logic [2:0]            slot_q;
	logic [2:0]            km1;
	logic [CW-1:0]         wm1;
	logic [CW-1:0]         eff_col;
	logic                  push;
	q_item_t               entry;
	q_item_t               fifo_q [4];
	logic [1:0]            wp_q;
	logic [1:0]            rp_q;
	logic [2:0]            cnt_q;

	// hold configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksel_q <= 2'd0;
			pw_q   <= 11'd1024;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_KSIZE) begin
				ksel_q <= cfg_data[1:0];
			end else if (cfg_index == CFG_WIDTH) begin
				pw_q <= cfg_data;
			end
		end
	end

	// classify the incoming transaction against the current raster position
	always_comb begin
		case (ksel_q)
			2'd0:    km1 = 3'd2;
			2'd1:    km1 = 3'd4;
			default: km1 = 3'd6;
		endcase
		if (pw_q == '0) begin
			wm1 = '0;
		end else if ({2'b00, pw_q} > 13'(LINE_MAX)) begin
			wm1 = CW'(LINE_MAX - 1);
		end else begin
			wm1 = CW'(pw_q - 11'd1);
		end
		eff_col = (col_q > wm1) ? wm1 : col_q;

		entry.is_pixel  = (item.func == FUNC_PIXEL);
		entry.w_row     = item.weight_row;
		entry.w_col     = item.weight_col;
		entry.w_value   = item.weight_value;
		entry.red       = item.in_red;
		entry.green     = item.in_green;
		entry.blue      = item.in_blue;
		entry.col       = COL_W'(eff_col);
		entry.slot      = slot_q;
		entry.km1       = km1;
		entry.fire      = (row_q >= km1) && (eff_col >= CW'(km1));
		entry.row_end   = (eff_col == wm1);
		entry.frame_end = item.in_frame_end;
	end

	assign item_ready = (cnt_q != 3'd4);
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != 3'd0);
	assign q_item     = fifo_q[rp_q];

	// advance raster counters on each accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (push && entry.is_pixel) begin
			if (item.in_frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end else if (eff_col == wm1) begin
				col_q  <= '0;
				slot_q <= (slot_q == 3'd6) ? 3'd0 : slot_q + 3'd1;
				if (row_q < 3'd6) begin
					row_q <= row_q + 3'd1;
				end
			end else begin
				col_q <= eff_col + CW'(1);
			end
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (q_pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b00, push} - {2'b00, q_pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= entry;
		end
	end

endmodule

// ===== hw/rtl/rnc_div.sv =====
// Shared restoring divider for three channel sums, one quotient bit per cycle.
// Truncates toward zero and saturates to the channel range. Depends on rnc_pkg.
module rnc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rnc_pkg::acc_t       dividend [3],
	input  rnc_pkg::sum_t       divisor,
	output logic                done,
	output rnc_pkg::chan_res_t  res [3]
);
	import rnc_pkg::*;

	localparam int CNT_W = $clog2(ACC_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] dmag_q;
	logic [SUM_W-1:0] rem_q [3];
	logic [ACC_W-1:0] quo_q [3];
	logic             neg_q [3];
	logic [SUM_W:0]   trial [3];
	logic             ge    [3];
	logic             qneg  [3];
	logic             over  [3];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// trial subtract per channel
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial[ch] = {rem_q[ch], quo_q[ch][ACC_W-1]};
			ge[ch]    = (trial[ch] >= {1'b0, dmag_q});
		end
	end

	// shift in one quotient bit each cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dmag_q <= divisor[SUM_W-1] ? SUM_W'(-divisor) : SUM_W'(divisor);
			for (int ch = 0; ch < 3; ch++) begin
				quo_q[ch] <= dividend[ch][ACC_W-1] ? ACC_W'(-dividend[ch])
				                                   : ACC_W'(dividend[ch]);
				rem_q[ch] <= '0;
				neg_q[ch] <= dividend[ch][ACC_W-1] ^ divisor[SUM_W-1];
			end
		end else if (busy_q) begin
			for (int ch = 0; ch < 3; ch++) begin
				rem_q[ch] <= ge[ch] ? SUM_W'(trial[ch] - {1'b0, dmag_q})
				                    : SUM_W'(trial[ch]);
				quo_q[ch] <= {quo_q[ch][ACC_W-2:0], ge[ch]};
			end
		end
	end

	// saturate the signed quotient
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			qneg[ch] = neg_q[ch] && (quo_q[ch] != '0);
			over[ch] = (quo_q[ch] > ACC_W'({CH_BITS{1'b1}}));
			res[ch].clip = qneg[ch] || over[ch];
			if (qneg[ch]) begin
				res[ch].val = '0;
			end else if (over[ch]) begin
				res[ch].val = {CH_BITS{1'b1}};
			end else begin
				res[ch].val = quo_q[ch][CH_BITS-1:0];
			end
		end
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/rnc_back.sv =====
// Back end: weight table, line store, tap sequencer with multiply-accumulate,
// divider launch and result register. Depends on rnc_pkg and rnc_div.
module rnc_back #(
	parameter int LINE_MAX = rnc_pkg::LINE_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  rnc_pkg::q_item_t    q_item,
	output logic                result_valid,
	input  logic                result_ready,
	output rnc_pkg::out_item_t  result
);
	import rnc_pkg::*;

	localparam int CW = $clog2(LINE_MAX);
	localparam int PW = CH_BITS + W_BITS + 1;

	logic [3*CH_BITS-1:0]     line_mem [MAX_K][LINE_MAX];
	logic signed [W_BITS-1:0] wtab     [MAX_K][MAX_K];
	logic [MAX_K-1:0][MAX_K-1:0] wvalid_q;

	back_state_t state_q, state_d;
	q_item_t     item_q;
	logic [2:0]  tr_q, tc_q, rs_q;
	logic [CW-1:0] cc_q, cstart_q;
	logic [3:0]  ss;
	logic [2:0]  s0;
	logic        tap_last;
	logic        div_start, out_load, div_done;

	logic [3*CH_BITS-1:0]     pix_s1;
	logic signed [W_BITS-1:0] wt_s1;
	logic                     wv_s1, v_s1;
	logic signed [W_BITS-1:0] w_eff;
	logic signed [PW-1:0]     prod_s2 [3];
	logic signed [W_BITS-1:0] w_s2;
	logic                     v_s2;
	acc_t                     acc_q [3];
	sum_t                     sum_q;
	chan_res_t                dres  [3];
	out_item_t                result_q;
	logic                     result_valid_q;

	assign tap_last = (tr_q == item_q.km1) && (tc_q == item_q.km1);
	assign ss = {1'b0, q_item.slot} + 4'd7 - {1'b0, q_item.km1};
	assign s0 = (ss >= 4'd7) ? 3'(ss - 4'd7) : ss[2:0];

	// next state
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.is_pixel && q_item.fire) begin
						state_d = ST_TAPS;
					end
				end
			end
			ST_TAPS: begin
				if (tap_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					if (sum_q == '0) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// tap counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q     <= '0;
			tc_q     <= '0;
			rs_q     <= '0;
			cc_q     <= '0;
			cstart_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wvalid_q <= '0;
		end else begin
			v_s1 <= (state_q == ST_TAPS);
			v_s2 <= v_s1;
			if (q_pop) begin
				tr_q     <= '0;
				tc_q     <= '0;
				rs_q     <= s0;
				cc_q     <= q_item.col[CW-1:0] - CW'(q_item.km1);
				cstart_q <= q_item.col[CW-1:0] - CW'(q_item.km1);
				if (!q_item.is_pixel && q_item.w_row < 3'd7 && q_item.w_col < 3'd7) begin
					wvalid_q[q_item.w_row][q_item.w_col] <= 1'b1;
				end
			end else if (state_q == ST_TAPS) begin
				if (tc_q == item_q.km1) begin
					tc_q <= '0;
					tr_q <= tr_q + 3'd1;
					rs_q <= (rs_q == 3'd6) ? 3'd0 : rs_q + 3'd1;
					cc_q <= cstart_q;
				end else begin
					tc_q <= tc_q + 3'd1;
					cc_q <= cc_q + CW'(1);
				end
			end
		end
	end

	// hold the popped item
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	// line store: write the pixel on pop, read one tap a cycle
	always_ff @(posedge clk) begin
		if (q_pop && q_item.is_pixel) begin
			line_mem[q_item.slot][q_item.col[CW-1:0]] <= {q_item.blue, q_item.green, q_item.red};
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= line_mem[rs_q][cc_q];
	end

	// weight table
	always_ff @(posedge clk) begin
		if (q_pop && !q_item.is_pixel && q_item.w_row < 3'd7 && q_item.w_col < 3'd7) begin
			wtab[q_item.w_row][q_item.w_col] <= q_item.w_value;
		end
	end

	always_ff @(posedge clk) begin
		wt_s1 <= wtab[tr_q][tc_q];
		wv_s1 <= wvalid_q[tr_q][tc_q];
	end

	// multiply stage
	assign w_eff = wv_s1 ? wt_s1 : '0;
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			prod_s2[ch] <= $signed({1'b0, pix_s1[ch*CH_BITS +: CH_BITS]}) * w_eff;
		end
		w_s2 <= w_eff;
	end

	// accumulate channel sums and the active weight sum
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= '0;
			end
			sum_q <= '0;
		end else if (v_s2) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= acc_q[ch] + ACC_W'(prod_s2[ch]);
			end
			sum_q <= sum_q + SUM_W'(w_s2);
		end
	end

	rnc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (sum_q),
		.done     (div_done),
		.res      (dres)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (sum_q == '0) begin
				result_q.out_red   <= '0;
				result_q.out_green <= '0;
				result_q.out_blue  <= '0;
				result_q.zero_sum  <= 1'b1;
				result_q.clipped   <= 1'b0;
			end else begin
				result_q.out_red   <= dres[0].val;
				result_q.out_green <= dres[1].val;
				result_q.out_blue  <= dres[2].val;
				result_q.zero_sum  <= 1'b0;
				result_q.clipped   <= dres[0].clip || dres[1].clip || dres[2].clip;
			end
			result_q.out_row_end   <= item_q.row_end;
			result_q.out_frame_end <= item_q.frame_end;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE))
		else $error("item popped while busy");
	a_div_drained: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!v_s1 && !v_s2))
		else $error("divider started before accumulation drained");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!result_valid_q || result_ready))
		else $error("result register overwritten");
	a_taps_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAPS && tap_last) |=> (state_q == ST_DRAIN))
		else $error("tap sequence did not end");

endmodule

// ===== hw/rtl/rgb_normalized_convolution_filter_unit.sv =====
// Top level of the RGB normalized convolution filter unit.
// Instantiates rnc_front and rnc_back; depends on rnc_pkg.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes kernel size
//   (index 0) and padded line width (index 1); write only while the unit is idle.
//   item channel carries weight loads (func 0) and padded pixels in raster order
//   (func 1). result channel returns one filtered pixel per pixel with a full
//   window, with row end, frame end, zero sum and clip flags.
// Back-end sequence: a weight item or a pixel without a full window is popped
//   and done. A pixel with a full window is popped, then the single tap sequencer
//   reads one line store entry per cycle for the k*k taps, the multiply/accumulate
//   pipeline drains, the bit-serial divider produces its 24 quotient bits, and the
//   result is loaded. The back end pops the next item only after that load.
// A zero weight sum skips the divider.
// A four-entry queue lets the front accept items while the back end computes.
// Reset clears the weight table (through per-entry valid bits), counters and the
//   configuration (3x3 kernel, width 1024); the line store is not cleared.
// When the receiver stalls, the result holds in its register; the back end waits
//   with the next result, and the front keeps accepting until the queue fills.
module rgb_normalized_convolution_filter_unit #(
	parameter int LINE_MAX = rnc_pkg::LINE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rnc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  rnc_pkg::in_item_t              item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output rnc_pkg::out_item_t             result
);
	import rnc_pkg::*;

	logic    q_valid;
	logic    q_pop;
	q_item_t q_item;

	rnc_front #(.LINE_MAX(LINE_MAX)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item)
	);

	rnc_back #(.LINE_MAX(LINE_MAX)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== tb/sv/rnc_checker.sv =====
// Checker for the RGB normalized convolution filter unit: watches the config, item and
// result channels, predicts each filtered pixel and compares it with the block's output.
// Depends on rnc_pkg.
module rnc_checker
	import rnc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  in_item_t               item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  out_item_t              result,
	output int                     pending,
	output int                     errors
);

	// predicted block state
	logic signed [W_BITS-1:0] weights [MAX_K][MAX_K];
	logic [3*CH_BITS-1:0]     lines [MAX_K][LINE_MAX_DEF];
	int                       col_cnt;
	int                       row_cnt;
	int                       line_slot;
	int                       ksel;
	int                       line_width;
	int                       err_n;
	out_item_t                filtered_q [$];

	initial begin
		for (int r = 0; r < MAX_K; r++)
			for (int c = 0; c < MAX_K; c++)
				weights[r][c] = '0;
		col_cnt    = 0;
		row_cnt    = 0;
		line_slot  = 0;
		ksel       = 0;
		line_width = LINE_MAX_DEF;
		err_n      = 0;
		pending    = 0;
		errors     = 0;
	end

	// Store the pixel, compute the normalized window sum if one exists, advance counters
	task filter_pixel(input in_item_t it);
		int              w;
		int              k;
		int              sl;
		int              wsum;
		longint          acc [3];
		longint          q;
		bit              clip;
		bit              zs;
		logic [7:0]      ch_out [3];
		logic [23:0]     px;
		out_item_t       o;
		w = line_width;
		if (w < 1) w = 1;
		if (w > LINE_MAX_DEF) w = LINE_MAX_DEF;
		if (col_cnt >= w) col_cnt = w - 1;
		lines[line_slot][col_cnt] = {it.in_blue, it.in_green, it.in_red};
		k = (ksel >= 2) ? 7 : 3 + 2 * ksel;
		if (row_cnt >= k - 1 && col_cnt >= k - 1) begin
			wsum = 0;
			for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
			for (int r = 0; r < k; r++) begin
				sl = (line_slot + MAX_K - (k - 1) + r) % MAX_K;
				for (int c = 0; c < k; c++) begin
					px = lines[sl][col_cnt - (k - 1) + c];
					wsum += int'(weights[r][c]);
					for (int ch = 0; ch < 3; ch++)
						acc[ch] += longint'(px[8*ch +: 8]) * longint'(weights[r][c]);
				end
			end
			zs   = (wsum == 0);
			clip = 0;
			for (int ch = 0; ch < 3; ch++) begin
				if (zs) begin
					ch_out[ch] = '0;
				end else begin
					q = acc[ch] / longint'(wsum);
					if (q < 0) begin
						clip = 1;
						ch_out[ch] = 8'd0;
					end else if (q > 255) begin
						clip = 1;
						ch_out[ch] = 8'd255;
					end else begin
						ch_out[ch] = q[7:0];
					end
				end
			end
			o.out_red       = ch_out[0];
			o.out_green     = ch_out[1];
			o.out_blue      = ch_out[2];
			o.out_row_end   = (col_cnt == w - 1);
			o.out_frame_end = it.in_frame_end;
			o.zero_sum      = zs;
			o.clipped       = clip;
			filtered_q.push_back(o);
		end
		if (it.in_frame_end) begin
			col_cnt   = 0;
			row_cnt   = 0;
			line_slot = 0;
		end else if (col_cnt == w - 1) begin
			col_cnt   = 0;
			line_slot = (line_slot + 1) % MAX_K;
			if (row_cnt < MAX_K - 1) row_cnt++;
		end else begin
			col_cnt++;
		end
	endtask

	task check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			err_n++;
		end
	endtask

	// Track every transaction on the three channels
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KSIZE: ksel = int'(cfg_data[1:0]);
					CFG_WIDTH: line_width = int'(cfg_data);
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				if (item.func == FUNC_WEIGHT) begin
					if (item.weight_row < MAX_K && item.weight_col < MAX_K)
						weights[item.weight_row][item.weight_col] = item.weight_value;
				end else begin
					filter_pixel(item);
				end
			end
			if (result_valid && result_ready) begin
				if (filtered_q.size() == 0) begin
					$error("result transaction with no pixel expected");
					err_n++;
				end else begin
					e = filtered_q.pop_front();
					check_field("out_red", e.out_red, result.out_red);
					check_field("out_green", e.out_green, result.out_green);
					check_field("out_blue", e.out_blue, result.out_blue);
					check_field("out_row_end", e.out_row_end, result.out_row_end);
					check_field("out_frame_end", e.out_frame_end, result.out_frame_end);
					check_field("zero_sum", e.zero_sum, result.zero_sum);
					check_field("clipped", e.clipped, result.clipped);
				end
			end
		end
		pending <= filtered_q.size();
		errors  <= err_n;
	end

endmodule

// ===== tb/sv/tb_rgb_normalized_convolution_filter_unit.sv =====
// Testbench top for the RGB normalized convolution filter unit: drives config writes,
// weight loads and padded frames under random idling, and reports the verdict.
// Depends on rnc_pkg, rnc_checker and the unit itself.
module tb_rgb_normalized_convolution_filter_unit;
	import rnc_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	in_item_t              item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	out_item_t             result;
	int                    pending;
	int                    errors;

	int tx_idle = 36;
	int rx_idle = 55;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int phase_items;
	int cur_k;

	rgb_normalized_convolution_filter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	rnc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.pending      (pending),
		.errors       (errors)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Drive result ready: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			result_ready <= 1'b0;
			hold_left <= 600;
			hold_done <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item, idling at random first; hold it until the transaction completes
	task send_item(input in_item_t it);
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		phase_items++;
	endtask

	task send_weight(input int r, input int c, input int v);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.func = FUNC_WEIGHT;
		it.weight_row = r[2:0];
		it.weight_col = c[2:0];
		it.weight_value = v[7:0];
		send_item(it);
	endtask

	task send_pixel(input int red, input int green, input int blue, input bit fend);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.func = FUNC_PIXEL;
		it.in_red = red[7:0];
		it.in_green = green[7:0];
		it.in_blue = blue[7:0];
		it.in_frame_end = fend;
		send_item(it);
	endtask

	// Mostly small weights inside the active kernel, sometimes anything
	task send_rand_weight();
		int r;
		int c;
		int v;
		r = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(cur_k - 1);
		c = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(cur_k - 1);
		v = ($urandom_range(6) == 0) ? $urandom_range(255) : $urandom_range(8);
		send_weight(r, c, v);
	endtask

	function automatic int rand_chan();
		case ($urandom_range(7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Send one frame of npix pixels with rare weight loads mixed in
	task send_frame(input int npix);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(99) < 3) send_rand_weight();
			send_pixel(rand_chan(), rand_chan(), rand_chan(), i == npix - 1);
		end
	endtask

	// Drop valid and let the block drain before touching registers
	task wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task write_config(input int ksel, input int width);
		wait_drained();
		cfg_index <= CFG_KSIZE;
		cfg_data <= ksel[CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_WIDTH;
		cfg_data <= width[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_k = (ksel >= 2) ? 7 : 3 + 2 * ksel;
	endtask

	task run_phase(input int idx, input int ksel, input int width);
		int weff;
		int rows;
		int npix;
		write_config(ksel, width);
		tx_idle = (idx < 3) ? 36 : (idx < 6) ? 55 : 0;
		rx_idle = (idx < 3) ? 55 : (idx < 6) ? 36 : 0;
		if (idx == 1) hold_req <= 1'b1;
		weff = (width < 1) ? 1 : (width > LINE_MAX_DEF) ? LINE_MAX_DEF : width;
		phase_items = 0;
		if (idx == 3) begin
			// clear the whole table so the sum starts at zero
			for (int r = 0; r < MAX_K; r++)
				for (int c = 0; c < MAX_K; c++)
					send_weight(r, c, 0);
		end else begin
			repeat (10 + $urandom_range(20)) send_rand_weight();
		end
		if (weff == LINE_MAX_DEF) begin
			send_frame(LINE_MAX_DEF + 8);
		end else begin
			phase_items = 0;
			while (phase_items < 80) begin
				rows = (weff < cur_k) ? 3 : $urandom_range(cur_k, cur_k + 2);
				npix = rows * weff;
				if ($urandom_range(3) == 0) npix -= $urandom_range(weff - 1);
				if (npix < 1) npix = 1;
				send_frame(npix);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero-sum frame, extreme and ignored weights, dropped frame end
		write_config(0, 3);
		for (int i = 0; i < 9; i++) send_pixel(i * 31, 255 - i * 31, 128, i == 8);
		send_weight(0, 0, -128);
		send_weight(1, 1, 127);
		send_weight(2, 2, 1);
		send_weight(7, 0, 5);
		send_weight(0, 7, 5);
		send_weight(6, 6, -3);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 2) ? 255 : 0, (i % 3) ? 0 : 255, 255, i == 8);
		for (int i = 0; i < 4; i++) send_pixel(255, 255, 255, i == 3);

		// random phases over kernel sizes and widths, extremes included
		run_phase(0, 2, 7);
		run_phase(1, 1, 9);
		run_phase(2, 0, 2047);
		run_phase(3, 3, 11);
		run_phase(4, 0, 16);
		run_phase(5, 2, 5);
		run_phase(6, 0, 0);
		run_phase(7, 1, 6);
		run_phase(8, 2, 30);
		run_phase(9, 1, 20);

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
